>>> rtl/swma_pkg.sv
// Shared constants, types and codes for the sliding window median alert block.
package swma_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int NUM_BINS   = 256;
   localparam int BIN_ADDR_W = 8;
   localparam int COUNT_W    = 11;
   localparam int LEN_W      = 11;
   localparam int WINDOW_MAX = 1024;
   localparam int POS_W      = 10;
   localparam int DMED_W     = 9;
   localparam int TOTAL_W    = 32;

   typedef logic [1:0] alu_op_type;

   localparam alu_op_type ALU_ADD = 2'd0;
   localparam alu_op_type ALU_INC = 2'd1;
   localparam alu_op_type ALU_DEC = 2'd2;

   typedef struct packed {
      logic                  clear;
      logic                  rd_en;
      logic [BIN_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [BIN_ADDR_W-1:0] wr_addr;
   } hist_ctrl_type;

endpackage

>>> rtl/swma_alu.sv
// Shared count adder: accumulate, increment, or decrement with floor at zero.
module swma_alu (
   input  swma_pkg::alu_op_type           op,
   input  logic [swma_pkg::COUNT_W-1:0]   a,
   input  logic [swma_pkg::COUNT_W-1:0]   b,
   output logic [swma_pkg::COUNT_W-1:0]   y
);
   import swma_pkg::*;

   logic [COUNT_W-1:0] operand;
   logic               hold;

   always_comb begin
      operand = '0;
      hold    = 1'b0;
      case (op)
         ALU_ADD: begin
            operand = b;
         end
         ALU_INC: begin
            operand = COUNT_W'(1);
         end
         ALU_DEC: begin
            operand = '1;
            hold    = (a == '0);
         end
         default: begin
            operand = '0;
         end
      endcase
   end

   assign y = hold ? a : (a + operand);

endmodule

>>> rtl/swma_hist.sv
// Histogram memory of per-value counts, with per-bin valid bits that read as zero.
module swma_hist (
   input  logic                          clock,
   input  logic                          reset,
   input  swma_pkg::hist_ctrl_type       ctrl,
   input  logic [swma_pkg::COUNT_W-1:0]  wr_data,
   output logic [swma_pkg::COUNT_W-1:0]  rd_data
);
   import swma_pkg::*;

   logic [COUNT_W-1:0]  mem [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [COUNT_W-1:0]  q_ff;
   logic                q_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         q_ff       <= mem[ctrl.rd_addr];
         q_valid_ff <= valid_ff[ctrl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[ctrl.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

>>> rtl/swma_ring.sv
// Ring memory of the samples in the current window, in arrival order.
module swma_ring (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [swma_pkg::POS_W-1:0]     wr_addr,
   input  logic [swma_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [swma_pkg::POS_W-1:0]     rd_addr,
   output logic [swma_pkg::SAMPLE_W-1:0]  rd_data
);
   import swma_pkg::*;

   logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
   logic [SAMPLE_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   assign rd_data = q_ff;

endmodule

>>> rtl/sliding_window_median_alert.sv
// Top level: sequencer around the histogram, ring and shared count adder.
//
// One sample word enters on req_valid/req_stall; one result word leaves on
// rsp_valid/rsp_stall for every sample. req_stall is high while a sample is
// being worked on.
// While the window is filling, the sample's bin is read and incremented and the
// result register is then loaded. Once the window is full, the histogram is first
// scanned bin by bin, 256 reads through one registered memory port feeding the
// shared adder, then the oldest sample is read from the ring and its bin
// decremented, and the new sample's bin incremented.
// The result register parts the two sides: a new sample is taken while a
// result waits; a stalled result holds and the next one waits in its final
// step until the register frees.
// csr_write_enable loads the window length (0 counts as 1, above 1024 as
// 1024) and restarts the window; the alert total is kept. Write it only
// while the block is idle.
// Reset (synchronous) empties the window at once through per-bin valid bits,
// sets the length to 1 and clears the alert total; no clearing pass is needed.
module sliding_window_median_alert (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swma_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_alert,
   output logic [swma_pkg::DMED_W-1:0]    rsp_doubled_median,
   output logic                           rsp_window_ready,
   output logic [swma_pkg::TOTAL_W-1:0]   rsp_alert_total,
   input  logic                           csr_write_enable,
   input  logic [swma_pkg::LEN_W-1:0]     csr_write_data
);
   import swma_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_RING_RD = 3'd2;
   localparam logic [2:0] ST_OLD_RD  = 3'd3;
   localparam logic [2:0] ST_OLD_WR  = 3'd4;
   localparam logic [2:0] ST_NEW_RD  = 3'd5;
   localparam logic [2:0] ST_NEW_WR  = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0]            state_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_in;
   logic [POS_W-1:0]      pos_ff;
   logic [LEN_W-1:0]      filled_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic                  full_ff;
   logic [BIN_ADDR_W:0]   issue_ff;
   logic [BIN_ADDR_W-1:0] proc_idx_ff;
   logic                  data_vld_ff;
   logic [COUNT_W-1:0]    cum_ff;
   logic                  lo_found_ff;
   logic                  hi_found_ff;
   logic [BIN_ADDR_W-1:0] lo_val_ff;
   logic [BIN_ADDR_W-1:0] hi_val_ff;
   logic [BIN_ADDR_W-1:0] old_ff;
   logic                  alert_ff;
   logic [DMED_W-1:0]     dmed_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_alert_ff;
   logic [DMED_W-1:0]     rsp_dmed_ff;
   logic                  rsp_ready_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   hist_ctrl_type         hist_ctrl;
   logic [COUNT_W-1:0]    hist_q;
   logic [SAMPLE_W-1:0]   ring_q;
   logic                  ring_wr_en;
   logic                  ring_rd_en;
   alu_op_type            alu_op;
   logic [COUNT_W-1:0]    alu_a;
   logic [COUNT_W-1:0]    alu_y;

   logic                  req_take;
   logic                  out_free;
   logic [POS_W-1:0]      pos_eff;
   logic [LEN_W-1:0]      pos_inc;
   logic [POS_W-1:0]      pos_in;
   logic [POS_W-1:0]      lo_rank;
   logic [POS_W-1:0]      hi_rank;
   logic                  lo_hit;
   logic                  hi_hit;
   logic [BIN_ADDR_W-1:0] lo_pick;
   logic [BIN_ADDR_W-1:0] hi_pick;
   logic [DMED_W-1:0]     dmed_in;
   logic                  scan_last;
   logic                  alert_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (csr_write_data == '0) begin
         len_in = LEN_W'(1);
      end else if (csr_write_data > LEN_W'(WINDOW_MAX)) begin
         len_in = LEN_W'(WINDOW_MAX);
      end else begin
         len_in = csr_write_data;
      end
   end

   assign pos_eff = ({1'b0, pos_ff} >= len_ff) ? '0 : pos_ff;
   assign pos_inc = {1'b0, pos_eff} + LEN_W'(1);
   assign pos_in  = (pos_inc >= len_ff) ? '0 : pos_inc[POS_W-1:0];

   assign lo_rank   = POS_W'((len_ff - LEN_W'(1)) >> 1);
   assign hi_rank   = POS_W'(len_ff >> 1);
   assign lo_hit    = !lo_found_ff && (alu_y > {1'b0, lo_rank});
   assign hi_hit    = !hi_found_ff && (alu_y > {1'b0, hi_rank});
   assign lo_pick   = lo_hit ? proc_idx_ff : lo_val_ff;
   assign hi_pick   = hi_hit ? proc_idx_ff : hi_val_ff;
   assign dmed_in   = {1'b0, lo_pick} + {1'b0, hi_pick};
   assign scan_last = (state_ff == ST_SCAN) && data_vld_ff && (proc_idx_ff == '1);
   assign alert_in  = {1'b0, sample_ff} >= dmed_in;

   always_comb begin
      hist_ctrl         = '0;
      hist_ctrl.clear   = csr_write_enable;
      alu_op            = ALU_ADD;
      alu_a             = cum_ff;
      ring_rd_en        = 1'b0;
      ring_wr_en        = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            hist_ctrl.rd_en   = !issue_ff[BIN_ADDR_W];
            hist_ctrl.rd_addr = issue_ff[BIN_ADDR_W-1:0];
         end
         ST_RING_RD: begin
            ring_rd_en = 1'b1;
         end
         ST_OLD_RD: begin
            hist_ctrl.rd_en   = 1'b1;
            hist_ctrl.rd_addr = ring_q;
         end
         ST_OLD_WR: begin
            alu_op            = ALU_DEC;
            alu_a             = hist_q;
            hist_ctrl.wr_en   = 1'b1;
            hist_ctrl.wr_addr = old_ff;
         end
         ST_NEW_RD: begin
            hist_ctrl.rd_en   = 1'b1;
            hist_ctrl.rd_addr = sample_ff;
         end
         ST_NEW_WR: begin
            alu_op            = ALU_INC;
            alu_a             = hist_q;
            hist_ctrl.wr_en   = 1'b1;
            hist_ctrl.wr_addr = sample_ff;
            ring_wr_en        = 1'b1;
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   swma_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (hist_q),
      .y  (alu_y)
   );

   swma_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (hist_ctrl),
      .wr_data (alu_y),
      .rd_data (hist_q)
   );

   swma_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (pos_eff),
      .wr_data (sample_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (pos_eff),
      .rd_data (ring_q)
   );

   // sequencer and window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= LEN_W'(1);
         pos_ff    <= '0;
         filled_ff <= '0;
         total_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            len_ff    <= len_in;
            pos_ff    <= '0;
            filled_ff <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= (filled_ff >= len_ff) ? ST_SCAN : ST_NEW_RD;
               end
            end
            ST_SCAN: begin
               if (scan_last) begin
                  state_ff <= ST_RING_RD;
                  if (alert_in && (total_ff != '1)) begin
                     total_ff <= total_ff + TOTAL_W'(1);
                  end
               end
            end
            ST_RING_RD: begin
               state_ff <= ST_OLD_RD;
            end
            ST_OLD_RD: begin
               state_ff <= ST_OLD_WR;
            end
            ST_OLD_WR: begin
               state_ff <= ST_NEW_RD;
            end
            ST_NEW_RD: begin
               state_ff <= ST_NEW_WR;
            end
            ST_NEW_WR: begin
               state_ff <= ST_DONE;
               pos_ff   <= pos_in;
               if (!full_ff) begin
                  filled_ff <= filled_ff + LEN_W'(1);
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // per-word working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff   <= req_sample;
         full_ff     <= (filled_ff >= len_ff);
         issue_ff    <= '0;
         data_vld_ff <= 1'b0;
         cum_ff      <= '0;
         lo_found_ff <= 1'b0;
         hi_found_ff <= 1'b0;
         alert_ff    <= 1'b0;
         dmed_ff     <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (!issue_ff[BIN_ADDR_W]) begin
            issue_ff <= issue_ff + (BIN_ADDR_W+1)'(1);
         end
         data_vld_ff <= !issue_ff[BIN_ADDR_W];
         proc_idx_ff <= issue_ff[BIN_ADDR_W-1:0];
         if (data_vld_ff) begin
            cum_ff <= alu_y;
            if (lo_hit) begin
               lo_found_ff <= 1'b1;
               lo_val_ff   <= proc_idx_ff;
            end
            if (hi_hit) begin
               hi_found_ff <= 1'b1;
               hi_val_ff   <= proc_idx_ff;
            end
         end
         if (scan_last) begin
            dmed_ff  <= dmed_in;
            alert_ff <= alert_in;
         end
      end
      if (state_ff == ST_OLD_RD) begin
         old_ff <= ring_q;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_alert_ff <= alert_ff;
         rsp_dmed_ff  <= dmed_ff;
         rsp_ready_ff <= full_ff;
         rsp_total_ff <= total_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alert          = rsp_alert_ff;
   assign rsp_doubled_median = rsp_dmed_ff;
   assign rsp_window_ready   = rsp_ready_ff;
   assign rsp_alert_total    = rsp_total_ff;

endmodule

>>> rtl/swma_check.sv
// Port-level checks for the sliding window median alert block, bound to the top level.
module swma_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [swma_pkg::SAMPLE_W-1:0]  req_sample,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_alert,
   input logic [swma_pkg::DMED_W-1:0]    rsp_doubled_median,
   input logic                           rsp_window_ready,
   input logic [swma_pkg::TOTAL_W-1:0]   rsp_alert_total,
   input logic                           csr_write_enable,
   input logic [swma_pkg::LEN_W-1:0]     csr_write_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alert)
         && $stable(rsp_doubled_median) && $stable(rsp_window_ready)
         && $stable(rsp_alert_total))
      else $error("stalled result word changed");

   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_ready |-> !rsp_alert && (rsp_doubled_median == '0))
      else $error("alert or median shown while window filling");

   a_alert_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alert |-> (rsp_alert_total != '0))
      else $error("alert word with zero alert total");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample taken without going busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind sliding_window_median_alert swma_check u_swma_check (.*);
